FILE: rtl/core/fmtb_pkg.sv
package fmtb_pkg;

    // Tick counter width. Samples and boundaries are taken modulo 2^TIME_WIDTH.
    // Legal range is 32 to 64.
    localparam int TIME_WIDTH = 64;
    localparam int WORD_W     = 32;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 160;

    // Stride exponent of the boundary search, 0 .. TIME_WIDTH-1.
    localparam int STRIDE_W = $clog2(TIME_WIDTH);
    localparam logic [STRIDE_W-1:0] STRIDE_MAX = STRIDE_W'(TIME_WIDTH - 1);

    // Candidate boundary width: base plus shifted whole ratio plus carries.
    localparam int WIDE_W = TIME_WIDTH + WORD_W + 1;

    localparam int MSX_W = WORD_W + 10;
    localparam logic [9:0] US_PER_MS = 10'd1000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS_WHOLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS_FRAC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_TICK_WHOLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_TICK_FRAC   = 2'd3;

    localparam logic [WORD_W-1:0] TICKS_PER_MS_WHOLE_RST = 32'd1000;
    localparam logic [WORD_W-1:0] US_PER_TICK_WHOLE_RST  = 32'd1;

    localparam logic KIND_SYNC = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_in;
        logic                sync;
        logic                step_try;
        logic                step_finish;
        logic                diff;
        logic                mul;
        logic                out_load;
        logic [STRIDE_W-1:0] stride;
    } fmtb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic reached;
        logic step_ok;
    } fmtb_status_t;

endpackage

FILE: rtl/core/fmtb_datapath.sv
module fmtb_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wen,
    input  logic [fmtb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fmtb_pkg::WORD_W-1:0]           cfg_wdata,
    input  logic [fmtb_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                  s_tuser,
    input  fmtb_pkg::fmtb_cmd_t                   cmd,
    output fmtb_pkg::fmtb_status_t                status,
    output logic [fmtb_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import fmtb_pkg::*;

    logic [WORD_W-1:0]     tpms_whole_reg;
    logic [WORD_W-1:0]     tpms_frac_reg;
    logic [WORD_W-1:0]     uspt_whole_reg;
    logic [WORD_W-1:0]     uspt_frac_reg;

    logic [TIME_WIDTH-1:0] last_reg;
    logic [TIME_WIDTH-1:0] next_reg;
    logic [WORD_W-1:0]     next_frac_reg;
    logic [WORD_W-1:0]     ms_reg;

    logic [TIME_WIDTH-1:0] now_reg;
    logic                  kind_reg;
    logic [WORD_W-1:0]     atics_reg;
    logic [WORD_W-1:0]     pw_reg;
    logic [WORD_W-1:0]     pf_reg;
    logic [MSX_W-1:0]      msx_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [WORD_W-1:0]     whole_eff;
    logic [WIDE_W-1:0]     whole_sh;
    logic [WIDE_W-1:0]     frac_sum;
    logic [WIDE_W-1:0]     carries;
    logic [WIDE_W-1:0]     cand;
    logic [WORD_W-1:0]     stride_inc;
    logic [2*WORD_W-1:0]   prod_w;
    logic [2*WORD_W-1:0]   prod_f;
    logic [WORD_W-1:0]     elapsed;
    logic [63:0]           time_base;

    // A zero whole ratio counts as one tick per millisecond.
    assign whole_eff = (tpms_whole_reg == '0) ? WORD_W'(1) : tpms_whole_reg;

    // Boundary 2^stride steps past the current next boundary.
    assign whole_sh   = WIDE_W'(whole_eff) << cmd.stride;
    assign frac_sum   = (WIDE_W'(tpms_frac_reg) << cmd.stride) + WIDE_W'(next_frac_reg);
    assign carries    = frac_sum >> WORD_W;
    assign cand       = WIDE_W'(next_reg) + whole_sh + carries;
    assign stride_inc = WORD_W'(1) << cmd.stride;

    assign status.kind    = kind_reg;
    assign status.reached = (next_reg <= now_reg);
    assign status.step_ok = (cand[WIDE_W-1:TIME_WIDTH] == '0)
                            && (cand[TIME_WIDTH-1:0] <= now_reg);

    assign prod_w    = {{WORD_W{1'b0}}, atics_reg} * {{WORD_W{1'b0}}, uspt_whole_reg};
    assign prod_f    = {{WORD_W{1'b0}}, atics_reg} * {{WORD_W{1'b0}}, uspt_frac_reg};
    assign elapsed   = pw_reg + pf_reg;
    assign time_base = 64'(msx_reg) + 64'(elapsed);

    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpms_whole_reg <= TICKS_PER_MS_WHOLE_RST;
            tpms_frac_reg  <= '0;
            uspt_whole_reg <= US_PER_TICK_WHOLE_RST;
            uspt_frac_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_TICKS_PER_MS_WHOLE: tpms_whole_reg <= cfg_wdata;
                CFG_TICKS_PER_MS_FRAC:  tpms_frac_reg  <= cfg_wdata;
                CFG_US_PER_TICK_WHOLE:  uspt_whole_reg <= cfg_wdata;
                CFG_US_PER_TICK_FRAC:   uspt_frac_reg  <= cfg_wdata;
                default:                tpms_frac_reg  <= tpms_frac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            next_reg      <= TIME_WIDTH'(TICKS_PER_MS_WHOLE_RST);
            next_frac_reg <= '0;
            ms_reg        <= '0;
        end
        else if (cmd.sync)
        begin
            last_reg      <= now_reg;
            next_reg      <= now_reg + TIME_WIDTH'(whole_eff);
            next_frac_reg <= tpms_frac_reg;
            ms_reg        <= '0;
        end
        else if (cmd.step_try && status.step_ok)
        begin
            next_reg      <= cand[TIME_WIDTH-1:0];
            next_frac_reg <= frac_sum[WORD_W-1:0];
            ms_reg        <= ms_reg + stride_inc;
        end
        else if (cmd.step_finish)
        begin
            last_reg      <= next_reg;
            next_reg      <= cand[TIME_WIDTH-1:0];
            next_frac_reg <= frac_sum[WORD_W-1:0];
            ms_reg        <= ms_reg + WORD_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg  <= s_tdata[TIME_WIDTH-1:0];
            kind_reg <= s_tuser;
        end
        if (cmd.diff)
        begin
            atics_reg <= now_reg[WORD_W-1:0] - last_reg[WORD_W-1:0];
        end
        if (cmd.mul)
        begin
            pw_reg  <= prod_w[WORD_W-1:0];
            pf_reg  <= prod_f[2*WORD_W-1:WORD_W];
            msx_reg <= MSX_W'(ms_reg) * MSX_W'(US_PER_MS);
        end
        if (cmd.out_load)
        begin
            out_reg <= {next_reg[WORD_W-1:0], time_base, elapsed, ms_reg};
        end
    end

    a_sync_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sync |=> (ms_reg == '0) && (last_reg == $past(now_reg)))
        else $error("sync did not restart the time base at the sample");

    a_finish_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_finish |=> (ms_reg == $past(ms_reg) + WORD_W'(1))
                            && (last_reg == $past(next_reg)))
        else $error("final boundary step did not count one millisecond");

endmodule

FILE: rtl/core/fmtb_ctrl.sv
module fmtb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  fmtb_pkg::fmtb_status_t status,
    output fmtb_pkg::fmtb_cmd_t    cmd
);
    import fmtb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_UP     = 3'd2;
    localparam logic [2:0] ST_DOWN   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;
    localparam logic [2:0] ST_DIFF   = 3'd5;
    localparam logic [2:0] ST_MUL    = 3'd6;
    localparam logic [2:0] ST_SUM    = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [STRIDE_W-1:0] stride_reg;
    logic [STRIDE_W-1:0] stride_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic                accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_SUM) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.stride  = stride_reg;
        cmd.load_in = accept;
        state_next  = state_reg;
        stride_next = stride_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.kind == KIND_SYNC)
                begin
                    cmd.sync   = 1'b1;
                    state_next = ST_DIFF;
                end
                else if (status.reached)
                begin
                    stride_next = '0;
                    state_next  = ST_UP;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_UP:
            begin
                // Widen the stride while steps land, then narrow it back down.
                cmd.step_try = 1'b1;
                if (!status.step_ok || (stride_reg == STRIDE_MAX))
                begin
                    if (stride_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        stride_next = stride_reg - STRIDE_W'(1);
                        state_next  = ST_DOWN;
                    end
                end
                else
                begin
                    stride_next = stride_reg + STRIDE_W'(1);
                end
            end
            ST_DOWN:
            begin
                cmd.step_try = 1'b1;
                if (stride_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    stride_next = stride_reg - STRIDE_W'(1);
                end
            end
            ST_FINISH:
            begin
                cmd.stride      = '0;
                cmd.step_finish = 1'b1;
                state_next      = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = accept ? ST_CHECK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stride_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stride_reg    <= stride_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_finish_unit_stride: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (stride_reg == '0))
        else $error("boundary search ended with a nonzero stride");

    a_sum_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUM) && !out_free) |=> (state_reg == ST_SUM))
        else $error("result dropped while the output register was full");

endmodule

FILE: rtl/core/fractional_millisecond_timebase_core.sv
// Channel   Dir  Handshake            Payload
// cfg       in   cfg_wen              cfg_index selects register, cfg_wdata value
// s         in   s_tvalid/s_tready    s_tdata now_ticks, s_tuser kind
// m         out  m_tvalid/m_tready    m_tdata ms, elapsed us, time base, next boundary
//
// A sync beat or an advance beat that steps no boundary goes through the check,
// tick difference, multiply and sum steps of the controller.
// An advance beat that steps one or more boundaries adds the galloping boundary
// search and its final step before the tick difference.
// Reset clears the configuration to 1000 ticks and 1 us per tick and the time base.
// A full output register stalls the block in its sum step; the next beat is still
// taken while a finished result waits.

module fractional_millisecond_timebase_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_wen,
    input  logic [fmtb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmtb_pkg::WORD_W-1:0]        cfg_wdata,
    // Tick samples.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fmtb_pkg::IN_DATA_W-1:0]     s_tdata,   // [63:0] now_ticks
    input  logic                               s_tuser,   // [0] kind
    // Time base reports.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] milliseconds, [63:32] elapsed_us, [127:64] time_base_us,
    // [159:128] next_boundary_low
    output logic [fmtb_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import fmtb_pkg::*;

    // The controller sequences each beat: sync or boundary search, then the
    // report. The datapath holds the ratios, the time base state and the
    // output register, and tells the controller whether a search step lands.
    fmtb_cmd_t    cmd;
    fmtb_status_t status;

    fmtb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fmtb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule
